/* rtl/core/gn2d_pkg.sv */
// shared types, constants and table functions for the 2d gradient noise core
// no dependencies
package gn2d_pkg;

    localparam int FREQ_W  = 24;   // frequency register, unsigned fixed point
    localparam int GRAD_W  = 17;   // gradient component, signed q2.15 holding +-1.0
    localparam int NOISE_W = 19;   // corner dot products and blends before saturation
    localparam int OUT_W   = 16;   // noise result, signed q1.15

    localparam logic [FREQ_W-1:0] FREQ_RESET = 24'd4096;

    localparam logic [31:0] HASH_MUL_A = 32'd3284157443;
    localparam logic [31:0] HASH_MUL_B = 32'd1911520717;
    localparam logic [31:0] HASH_MUL_C = 32'd2048419325;

    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint Q30_HALF_PI = 64'sd1686629713;

    localparam logic signed [OUT_W-1:0] NOISE_MAX = 16'sh7fff;
    localparam logic signed [OUT_W-1:0] NOISE_MIN = 16'sh8000;

    // quadrant of the gradient angle
    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } quad_t;

    function automatic logic [31:0] rotl16(input logic [31:0] v);
        return {v[15:0], v[31:16]};
    endfunction

    // q2.30 multiply with truncation, operands non-negative
    function automatic longint q30_mul(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    // q2.30 to q1.15, round half up, negatives clamp to zero
    function automatic logic [GRAD_W-1:0] q30_to_q15(input longint v);
        longint c;
        c = (v < 0) ? 64'sd0 : v;
        return GRAD_W'((c + 64'sd16384) >>> 15);
    endfunction

    // angle inside the quarter circle for table index r, q2.30
    function automatic longint quarter_angle(input int unsigned r, input int unsigned qbits);
        return (longint'(r) * Q30_HALF_PI) >>> qbits;
    endfunction

    // sine by taylor series up to the ninth power
    function automatic logic [GRAD_W-1:0] taylor_sin(input int unsigned r,
                                                     input int unsigned qbits);
        longint x;
        longint x2;
        longint t;
        x  = quarter_angle(r, qbits);
        x2 = q30_mul(x, x);
        t  = Q30_ONE - x2 / 72;
        t  = Q30_ONE - q30_mul(x2, t) / 42;
        t  = Q30_ONE - q30_mul(x2, t) / 20;
        t  = Q30_ONE - q30_mul(x2, t) / 6;
        return q30_to_q15(q30_mul(x, t));
    endfunction

    // cosine by taylor series up to the tenth power
    function automatic logic [GRAD_W-1:0] taylor_cos(input int unsigned r,
                                                     input int unsigned qbits);
        longint x;
        longint x2;
        longint t;
        x  = quarter_angle(r, qbits);
        x2 = q30_mul(x, x);
        t  = Q30_ONE - x2 / 90;
        t  = Q30_ONE - q30_mul(x2, t) / 56;
        t  = Q30_ONE - q30_mul(x2, t) / 30;
        t  = Q30_ONE - q30_mul(x2, t) / 12;
        t  = Q30_ONE - q30_mul(x2, t) / 2;
        return q30_to_q15(t);
    endfunction

endpackage

/* rtl/core/gradient_noise_2d.sv */
// top level of the 2d gradient noise core: stream ports, frequency register, valid line
// depends on gn2d_pkg, gn2d_lattice, gn2d_hash, gn2d_grad, gn2d_dot, gn2d_blend
//
// Streaming 2d gradient (Perlin-style) noise generator. Each input transfer carries a
// signed pixel coordinate pair; each output transfer carries one signed q1.15 noise
// sample, in the same order. The coordinates are scaled by the frequency register
// (unsigned, FRAC_BITS fraction bits, reset 4096), the four surrounding lattice corners
// are hashed into angles that pick unit gradients from a sine/cosine table, and the
// corner dot products are blended bilinearly (no fade curve) and saturated. The core
// takes one transfer per clock while the output is not held, and has 11 register stages:
// the input transfer edge loads the first one, and the result moves through them to the
// output register. That depth comes from the chain of three 32-bit hash multiplies,
// the offset-by-gradient multipliers and the horizontal and vertical blend multipliers,
// each followed by a register. Every stage moves together: when a result waits at the
// output and m_tready is low, the pipeline holds and s_tready drops; empty stages are
// still filled while the output is free. Write cfg_wdata with cfg_we only while no
// transfer is in flight.
module gradient_noise_2d import gn2d_pkg::*; #(
    parameter int COORD_BITS       = 16,
    parameter int FRAC_BITS        = 16,
    parameter int ANGLE_TABLE_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // frequency register write
    input  logic                  cfg_we,
    input  logic [FREQ_W-1:0]     cfg_wdata,
    // coordinate stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [((2 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata, // pos_x, pos_y, zero pad
    // noise stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata                        // noise
);

    localparam int LAT    = 11;  // register stages from input to output
    localparam int DLY    = 5;   // offset delay from lattice stage to blend stage
    localparam int DOT_AT = 2;   // offset tap that lines up with the gradients

    // frequency register
    logic [FREQ_W-1:0] freq_reg, freq_next;

    // pipeline control
    logic           advance;
    logic [LAT-1:0] valid_reg, valid_next;

    // lattice outputs
    logic signed [COORD_BITS-1:0] pos_x, pos_y;
    logic [31:0]                  a0, a1, y0, y1;
    logic [FRAC_BITS-1:0]         fx, fy;

    // offset delay line, one entry per stage
    logic [FRAC_BITS-1:0] fx_dly_reg [DLY];
    logic [FRAC_BITS-1:0] fy_dly_reg [DLY];

    // per corner signals, corner order 00, 10, 01, 11
    logic [31:0]                  lane_a [4];
    logic [31:0]                  lane_y [4];
    logic [ANGLE_TABLE_BITS-1:0]  angle [4];
    logic signed [GRAD_W-1:0]     gx [4];
    logic signed [GRAD_W-1:0]     gy [4];
    logic signed [FRAC_BITS:0]    dx [4];
    logic signed [FRAC_BITS:0]    dy [4];
    logic signed [NOISE_W-1:0]    dot [4];
    logic signed [OUT_W-1:0]      noise;

    // config write
    assign freq_next = cfg_we ? cfg_wdata : freq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg <= FREQ_RESET;
        end else begin
            freq_reg <= freq_next;
        end
    end

    // the whole pipeline steps unless the output holds a result not yet taken
    assign advance    = m_tready || !valid_reg[LAT-1];
    assign s_tready   = advance;
    assign valid_next = {valid_reg[LAT-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg[LAT-1];
    assign m_tdata  = noise;

    // input unpack
    assign pos_x = $signed(s_tdata[COORD_BITS-1:0]);
    assign pos_y = $signed(s_tdata[2*COORD_BITS-1:COORD_BITS]);

    // scale and split, stages 1 and 2
    gn2d_lattice #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_lattice (
        .aclk  (aclk),
        .en    (advance),
        .pos_x (pos_x),
        .pos_y (pos_y),
        .freq  (freq_reg),
        .a0    (a0),
        .a1    (a1),
        .y0    (y0),
        .y1    (y1),
        .fx    (fx),
        .fy    (fy)
    );

    // offsets travel alongside the hash and gradient stages
    always_ff @(posedge aclk) begin
        if (advance) begin
            fx_dly_reg[0] <= fx;
            fy_dly_reg[0] <= fy;
            for (int i = 1; i < DLY; i++) begin
                fx_dly_reg[i] <= fx_dly_reg[i-1];
                fy_dly_reg[i] <= fy_dly_reg[i-1];
            end
        end
    end

    // corner wiring: x column picks the hash seed, y row picks the y word
    assign lane_a[0] = a0;
    assign lane_a[1] = a1;
    assign lane_a[2] = a0;
    assign lane_a[3] = a1;
    assign lane_y[0] = y0;
    assign lane_y[1] = y0;
    assign lane_y[2] = y1;
    assign lane_y[3] = y1;

    // offset toward each corner; a far corner is offset minus one
    assign dx[0] = $signed({1'b0, fx_dly_reg[DOT_AT]});
    assign dx[1] = $signed({1'b1, fx_dly_reg[DOT_AT]});
    assign dx[2] = $signed({1'b0, fx_dly_reg[DOT_AT]});
    assign dx[3] = $signed({1'b1, fx_dly_reg[DOT_AT]});
    assign dy[0] = $signed({1'b0, fy_dly_reg[DOT_AT]});
    assign dy[1] = $signed({1'b0, fy_dly_reg[DOT_AT]});
    assign dy[2] = $signed({1'b1, fy_dly_reg[DOT_AT]});
    assign dy[3] = $signed({1'b1, fy_dly_reg[DOT_AT]});

    for (genvar c = 0; c < 4; c++) begin : g_corner
        // hash, stages 3 and 4
        gn2d_hash #(
            .ANGLE_TABLE_BITS (ANGLE_TABLE_BITS)
        ) u_hash (
            .aclk  (aclk),
            .en    (advance),
            .a     (lane_a[c]),
            .y     (lane_y[c]),
            .angle (angle[c])
        );

        // gradient table, stage 5
        gn2d_grad #(
            .ANGLE_TABLE_BITS (ANGLE_TABLE_BITS)
        ) u_grad (
            .aclk  (aclk),
            .en    (advance),
            .angle (angle[c]),
            .gx    (gx[c]),
            .gy    (gy[c])
        );

        // dot product, stages 6 and 7
        gn2d_dot #(
            .FRAC_BITS (FRAC_BITS)
        ) u_dot (
            .aclk (aclk),
            .en   (advance),
            .dx   (dx[c]),
            .dy   (dy[c]),
            .gx   (gx[c]),
            .gy   (gy[c]),
            .dot  (dot[c])
        );
    end

    // bilinear blend and saturation, stages 8 to 11
    gn2d_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .aclk  (aclk),
        .en    (advance),
        .n00   (dot[0]),
        .n10   (dot[1]),
        .n01   (dot[2]),
        .n11   (dot[3]),
        .fx    (fx_dly_reg[DLY-1]),
        .fy    (fy_dly_reg[DLY-1]),
        .noise (noise)
    );

endmodule

/* rtl/core/gn2d_lattice.sv */
// coordinate scaling, lattice cell and offset split, first hash multiply per column
// depends on gn2d_pkg
module gn2d_lattice import gn2d_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    input  logic [FREQ_W-1:0]            freq,
    output logic [31:0]                  a0,
    output logic [31:0]                  a1,
    output logic [31:0]                  y0,
    output logic [31:0]                  y1,
    output logic [FRAC_BITS-1:0]         fx,
    output logic [FRAC_BITS-1:0]         fy
);

    localparam int PW    = COORD_BITS + FREQ_W + 1;
    localparam int EXT_W = FRAC_BITS + 32;

    logic signed [PW-1:0]    px_reg, py_reg, px_next, py_next;
    logic signed [EXT_W-1:0] px_ext, py_ext;
    logic [31:0]             x0, x1;
    logic [31:0]             a0_reg, a1_reg, y0_reg, y1_reg;
    logic [31:0]             a0_next, a1_next, y0_next, y1_next;
    logic [FRAC_BITS-1:0]    fx_reg, fy_reg;

    assign px_next = PW'(pos_x) * PW'($signed({1'b0, freq}));
    assign py_next = PW'(pos_y) * PW'($signed({1'b0, freq}));

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
    end

    // floor of the lattice position, wrapped to 32 bits
    assign px_ext  = EXT_W'(px_reg);
    assign py_ext  = EXT_W'(py_reg);
    assign x0      = px_ext[FRAC_BITS +: 32];
    assign x1      = x0 + 32'd1;
    assign y0_next = py_ext[FRAC_BITS +: 32];
    assign y1_next = y0_next + 32'd1;
    assign a0_next = x0 * HASH_MUL_A;
    assign a1_next = x1 * HASH_MUL_A;

    always_ff @(posedge aclk) begin
        if (en) begin
            a0_reg <= a0_next;
            a1_reg <= a1_next;
            y0_reg <= y0_next;
            y1_reg <= y1_next;
            fx_reg <= px_reg[FRAC_BITS-1:0];
            fy_reg <= py_reg[FRAC_BITS-1:0];
        end
    end

    assign a0 = a0_reg;
    assign a1 = a1_reg;
    assign y0 = y0_reg;
    assign y1 = y1_reg;
    assign fx = fx_reg;
    assign fy = fy_reg;

endmodule

/* rtl/core/gn2d_hash.sv */
// one corner lane of the multiply-xor-rotate hash, two register stages
// depends on gn2d_pkg
module gn2d_hash import gn2d_pkg::*; #(
    parameter int ANGLE_TABLE_BITS = 10
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [31:0]                 a,
    input  logic [31:0]                 y,
    output logic [ANGLE_TABLE_BITS-1:0] angle
);

    logic [31:0]                 a_reg, b_reg, b_next, h;
    logic [ANGLE_TABLE_BITS-1:0] angle_reg;

    assign b_next = (y ^ rotl16(a)) * HASH_MUL_B;

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg <= a;
            b_reg <= b_next;
        end
    end

    assign h = (a_reg ^ rotl16(b_reg)) * HASH_MUL_C;

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg <= h[31 -: ANGLE_TABLE_BITS];
        end
    end

    assign angle = angle_reg;

endmodule

/* rtl/core/gn2d_grad.sv */
// gradient lookup: quarter-circle sine and cosine tables plus quadrant fold
// depends on gn2d_pkg
module gn2d_grad import gn2d_pkg::*; #(
    parameter int ANGLE_TABLE_BITS = 10
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [ANGLE_TABLE_BITS-1:0] angle,
    output logic signed [GRAD_W-1:0]    gx,
    output logic signed [GRAD_W-1:0]    gy
);

    localparam int QB    = ANGLE_TABLE_BITS - 2;
    localparam int QSIZE = 1 << QB;

    logic [GRAD_W-1:0]        sin_tab [QSIZE];
    logic [GRAD_W-1:0]        cos_tab [QSIZE];
    logic [QB-1:0]            r;
    quad_t                    quad;
    logic signed [GRAD_W-1:0] c, s;
    logic signed [GRAD_W-1:0] gx_reg, gy_reg, gx_next, gy_next;

    for (genvar i = 0; i < QSIZE; i++) begin : g_tab
        assign sin_tab[i] = taylor_sin(i, QB);
        assign cos_tab[i] = taylor_cos(i, QB);
    end

    assign quad = quad_t'(angle[ANGLE_TABLE_BITS-1 -: 2]);
    assign r    = angle[QB-1:0];
    assign c    = $signed(cos_tab[r]);
    assign s    = $signed(sin_tab[r]);

    always_comb begin
        case (quad)
            QUAD_I: begin
                gx_next = c;
                gy_next = s;
            end
            QUAD_II: begin
                gx_next = -s;
                gy_next = c;
            end
            QUAD_III: begin
                gx_next = -c;
                gy_next = -s;
            end
            default: begin
                gx_next = s;
                gy_next = -c;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
        end
    end

    assign gx = gx_reg;
    assign gy = gy_reg;

endmodule

/* rtl/core/gn2d_dot.sv */
// corner dot product of gradient and offset, rounded to signed q4.15
// depends on gn2d_pkg
module gn2d_dot import gn2d_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic signed [FRAC_BITS:0]   dx,
    input  logic signed [FRAC_BITS:0]   dy,
    input  logic signed [GRAD_W-1:0]    gx,
    input  logic signed [GRAD_W-1:0]    gy,
    output logic signed [NOISE_W-1:0]   dot
);

    localparam int PXW = FRAC_BITS + 1 + GRAD_W;
    localparam int SW  = PXW + 1;
    localparam logic signed [SW-1:0] HALF = SW'(64'd1 << (FRAC_BITS - 1));

    logic signed [PXW-1:0]     prod_x_reg, prod_y_reg, prod_x_next, prod_y_next;
    logic signed [SW-1:0]      sum, shifted;
    logic signed [NOISE_W-1:0] dot_reg, dot_next;

    assign prod_x_next = PXW'(dx) * PXW'(gx);
    assign prod_y_next = PXW'(dy) * PXW'(gy);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
        end
    end

    // round half up: floor of (sum + half) by the offset scale
    assign sum      = SW'(prod_x_reg) + SW'(prod_y_reg);
    assign shifted  = (sum + HALF) >>> FRAC_BITS;
    assign dot_next = NOISE_W'(shifted);

    always_ff @(posedge aclk) begin
        if (en) begin
            dot_reg <= dot_next;
        end
    end

    assign dot = dot_reg;

endmodule

/* rtl/core/gn2d_blend.sv */
// bilinear blend of the four corner values and output saturation, four stages
// depends on gn2d_pkg
module gn2d_blend import gn2d_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic signed [NOISE_W-1:0]   n00,
    input  logic signed [NOISE_W-1:0]   n10,
    input  logic signed [NOISE_W-1:0]   n01,
    input  logic signed [NOISE_W-1:0]   n11,
    input  logic [FRAC_BITS-1:0]        fx,
    input  logic [FRAC_BITS-1:0]        fy,
    output logic signed [OUT_W-1:0]     noise
);

    localparam int DW = NOISE_W + 1;
    localparam int PW = DW + FRAC_BITS + 1;
    localparam int VW = NOISE_W + 2;
    localparam logic signed [PW-1:0] HALF = PW'(64'd1 << (FRAC_BITS - 1));

    // stage one: horizontal products
    logic signed [PW-1:0]      prod_t_reg, prod_b_reg, prod_t_next, prod_b_next;
    logic signed [NOISE_W-1:0] n00_reg, n01_reg;
    logic [FRAC_BITS-1:0]      fy1_reg, fy2_reg;
    // stage two: top and bottom rows
    logic signed [PW-1:0]      rnd_t, rnd_b;
    logic signed [NOISE_W-1:0] top_reg, bot_reg, top_next, bot_next;
    // stage three: vertical product
    logic signed [PW-1:0]      prod_v_reg, prod_v_next;
    logic signed [NOISE_W-1:0] top2_reg;
    // stage four: final sum and saturation
    logic signed [PW-1:0]      rnd_v;
    logic signed [VW-1:0]      v;
    logic signed [OUT_W-1:0]   noise_reg, noise_next;

    assign prod_t_next = PW'(DW'(n10) - DW'(n00)) * PW'($signed({1'b0, fx}));
    assign prod_b_next = PW'(DW'(n11) - DW'(n01)) * PW'($signed({1'b0, fx}));

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_t_reg <= prod_t_next;
            prod_b_reg <= prod_b_next;
            n00_reg    <= n00;
            n01_reg    <= n01;
            fy1_reg    <= fy;
        end
    end

    assign rnd_t    = (prod_t_reg + HALF) >>> FRAC_BITS;
    assign rnd_b    = (prod_b_reg + HALF) >>> FRAC_BITS;
    assign top_next = NOISE_W'(VW'(n00_reg) + VW'(rnd_t));
    assign bot_next = NOISE_W'(VW'(n01_reg) + VW'(rnd_b));

    always_ff @(posedge aclk) begin
        if (en) begin
            top_reg <= top_next;
            bot_reg <= bot_next;
            fy2_reg <= fy1_reg;
        end
    end

    assign prod_v_next = PW'(DW'(bot_reg) - DW'(top_reg)) * PW'($signed({1'b0, fy2_reg}));

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_v_reg <= prod_v_next;
            top2_reg   <= top_reg;
        end
    end

    assign rnd_v = (prod_v_reg + HALF) >>> FRAC_BITS;
    assign v     = VW'(top2_reg) + VW'(rnd_v);

    always_comb begin
        if (v > VW'(NOISE_MAX)) begin
            noise_next = NOISE_MAX;
        end else if (v < VW'(NOISE_MIN)) begin
            noise_next = NOISE_MIN;
        end else begin
            noise_next = OUT_W'(v);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            noise_reg <= noise_next;
        end
    end

    assign noise = noise_reg;

endmodule
